// File: rtl/hsps_pkg.sv
// Shared types, constants and syntax tables for the SPS header parser.
`default_nettype none
package hsps_pkg;

   localparam int MAX_GOLOMB_ZEROS   = 31;
   localparam int SCALING_FLAG_COUNT = 8;

   localparam logic [5:0] ST_DONE = 6'd44;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_NOT_SPS = 3'd1;
   localparam logic [2:0] STATUS_TRUNC   = 3'd2;
   localparam logic [2:0] STATUS_SAT     = 3'd3;
   localparam logic [2:0] STATUS_ZTICK   = 3'd4;

   localparam logic [3:0] SKIP_RESET = 4'd4;

   typedef struct packed {
      logic suffix;
      logic not_sps;
      logic over;
      logic complete;
      logic sat;
      logic timing;
      logic fixed;
   } flags_type;

   // Divider handshake between the parser and the divide unit.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   // Field width per syntax step; 0 is exp-Golomb.
   function automatic logic [5:0] width_of(input logic [5:0] step);
      logic [5:0] w;
      case (step)
         6'd0, 6'd1, 6'd2, 6'd3, 6'd31: w = 6'd8;
         6'd6, 6'd9, 6'd10, 6'd15, 6'd21, 6'd24, 6'd25, 6'd26, 6'd27,
         6'd29, 6'd30, 6'd33, 6'd34, 6'd35, 6'd38, 6'd40, 6'd43: w = 6'd1;
         6'd11: w = 6'(SCALING_FLAG_COUNT);
         6'd32, 6'd41, 6'd42: w = 6'd32;
         6'd36: w = 6'd5;
         6'd37: w = 6'd24;
         default: w = 6'd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: rtl/hsps_if.sv
// Valid/ready stream interfaces for the request, response and CSR channels.
`default_nettype none
interface hsps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hsps_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] width_pixels;
   logic [15:0] height_pixels;
   logic [31:0] frame_rate;
   modport source (output valid, output status, output width_pixels,
                   output height_pixels, output frame_rate, input ready);
   modport sink   (input valid, input status, input width_pixels,
                   input height_pixels, input frame_rate, output ready);
endinterface

interface hsps_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] skip_bytes;
   modport source (output valid, output skip_bytes, input ready);
   modport sink   (input valid, input skip_bytes, output ready);
endinterface
`default_nettype wire

// File: rtl/h264_sps_header_parser.sv
// Top level of the H.264 SPS header parser.
// Takes one NAL byte per request word and walks the SPS syntax one bit per
// clock through a shared bit-serial field unit, so a payload byte holds the
// block until all eight of its bits are walked, while skipped or
// emulation-prevention bytes are dropped on acceptance. On the word marked
// last_byte the frame rate is formed by a restoring divider, with start,
// done and post handoff, before the response word is posted; without a
// divide the post follows directly. A new request is accepted while that
// response waits to be taken. Timing: width/height are (count+1)*16 with
// saturation, frame_rate is the timing scale over the tick count, halved
// when the fixed-rate flag is set. Status: 0 ok, 1 not SPS, 2 truncated, 3
// saturated, 4 zero tick. skip_bytes (reset 4) may only be written while idle.
`default_nettype none
module h264_sps_header_parser
   import hsps_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   hsps_req_if.sink   req,
   hsps_rsp_if.source rsp,
   hsps_csr_if.sink   csr
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BITS  = 4'b0010,
      S_DIV   = 4'b0100,
      S_POST  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  skip_cfg_ff, skip_cfg_in;
   logic [3:0]  skip_cnt_ff, skip_cnt_in;
   logic [1:0]  zrun_ff, zrun_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic        last_ff, last_in;
   logic        rv_ff, rv_in;
   logic [2:0]  st_ff, st_in;
   logic [15:0] w_ff, w_in;
   logic [15:0] h_ff, h_in;
   logic [31:0] fr_ff, fr_in;

   logic        take;
   logic        bit_valid;
   logic        clear;
   flags_type   flags;
   logic [15:0] wst, hst;
   logic [31:0] tick, scale;
   div_req_type dreq;
   div_rsp_type drsp;

   hsps_bit_parser u_parser (
      .clock, .reset, .bit_valid, .bit_value(byte_ff[bit_idx_ff]), .clear,
      .flags, .width_store(wst), .height_store(hst), .tick_units(tick),
      .scale_value(scale)
   );

   hsps_divider u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   // Accept only while idle; a waiting response is held in its own register.
   assign req.ready = (state_ff == S_IDLE);
   assign take      = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign bit_valid = (state_ff == S_BITS);

   always_comb begin
      state_in = state_ff; skip_cfg_in = skip_cfg_ff; skip_cnt_in = skip_cnt_ff;
      zrun_in = zrun_ff; byte_in = byte_ff; bit_idx_in = bit_idx_ff;
      last_in = last_ff; rv_in = rv_ff; st_in = st_ff; w_in = w_ff; h_in = h_ff;
      fr_in = fr_ff; clear = 1'b0;
      dreq.start = 1'b0; dreq.dividend = scale; dreq.divisor = tick;
      if (csr.valid) skip_cfg_in = csr.skip_bytes;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (take) begin
            byte_in = req.data_byte; last_in = req.last_byte; bit_idx_in = 3'd7;
            if (skip_cnt_ff < skip_cfg_ff) begin
               skip_cnt_in = skip_cnt_ff + 4'd1;
               state_in = req.last_byte ? S_DIV : S_IDLE;
            end else if (zrun_ff == 2'd2 && req.data_byte == 8'h03) begin
               zrun_in = '0;
               state_in = req.last_byte ? S_DIV : S_IDLE;
            end else begin
               if (req.data_byte == 8'h00) begin
                  if (zrun_ff != 2'd2) zrun_in = zrun_ff + 2'd1;
               end else zrun_in = '0;
               state_in = S_BITS;
            end
         end
         S_BITS: begin
            bit_idx_in = bit_idx_ff - 3'd1;
            if (bit_idx_ff == 3'd0) state_in = last_ff ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            // Start divide only when it will be used; hold until it ends.
            if (!drsp.busy && !drsp.done) begin
               if (flags.complete && !flags.not_sps && !flags.over &&
                   flags.timing && tick != 0) dreq.start = 1'b1;
               else state_in = S_POST;
            end else if (drsp.done) state_in = S_POST;
         end
         S_POST: if (!rv_ff || rsp.ready) begin
            rv_in = 1'b1; w_in = '0; h_in = '0; fr_in = '0;
            if (flags.not_sps) st_in = STATUS_NOT_SPS;
            else if (flags.over) st_in = STATUS_SAT;
            else if (!flags.complete) st_in = STATUS_TRUNC;
            else begin
               st_in = STATUS_OK; w_in = wst; h_in = hst;
               if (flags.timing) begin
                  if (tick == 0) st_in = STATUS_ZTICK;
                  else fr_in = flags.fixed ? {1'b0, drsp.quotient[31:1]} : drsp.quotient;
               end
               if (flags.sat) st_in = STATUS_SAT;
            end
            clear = 1'b1; skip_cnt_in = '0; zrun_in = '0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in; bit_idx_ff <= bit_idx_in; last_ff <= last_in;
      st_ff <= st_in; w_ff <= w_in; h_ff <= h_in; fr_ff <= fr_in;
      if (reset) begin
         state_ff <= S_IDLE; skip_cfg_ff <= SKIP_RESET; skip_cnt_ff <= '0;
         zrun_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; skip_cfg_ff <= skip_cfg_in;
         skip_cnt_ff <= skip_cnt_in; zrun_ff <= zrun_in; rv_ff <= rv_in;
      end
   end

   assign rsp.valid         = rv_ff;
   assign rsp.status        = st_ff;
   assign rsp.width_pixels  = w_ff;
   assign rsp.height_pixels = h_ff;
   assign rsp.frame_rate    = fr_ff;

`ifndef NO_ASSERTIONS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready)
      else $error("request ready while busy");
   a_post_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POST && rv_ff && !rsp.ready |=> state_ff == S_POST)
      else $error("response overwritten");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      drsp.busy |-> state_ff == S_DIV)
      else $error("divider busy outside divide state");
`endif
endmodule
`default_nettype wire

// File: rtl/hsps_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hsps_divider
   import hsps_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_req_type req,
   output div_rsp_type rsp
);
   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end else begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without busy");
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0)
      else $error("divider busy with zero count");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/hsps_bit_parser.sv
// Bit-serial SPS syntax walker: one bit of the current byte per cycle while bit_valid is high.
`default_nettype none
module hsps_bit_parser
   import hsps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        bit_valid,
   input  wire logic        bit_value,
   input  wire logic        clear,
   output flags_type        flags,
   output logic [15:0]      width_store,
   output logic [15:0]      height_store,
   output logic [31:0]      tick_units,
   output logic [31:0]      scale_value
);
   logic [5:0]  step_ff, step_in;
   logic [5:0]  bcnt_ff, bcnt_in;
   logic [5:0]  gz_ff, gz_in;
   logic [31:0] fv_ff, fv_in;
   logic [7:0]  prof_ff, prof_in;
   logic [7:0]  cyc_ff, cyc_in;
   logic [15:0] wid_ff, wid_in;
   logic [15:0] hgt_ff, hgt_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] scale_ff, scale_in;
   flags_type   fl_ff, fl_in;

   logic [5:0]  w;
   logic        fin;
   logic [31:0] v;
   logic [31:0] shv;
   logic [5:0]  n;
   logic        stop_now;
   logic [32:0] full;
   logic [7:0]  cyc_dec;

   function automatic logic [15:0] size_of(input logic [31:0] x);
      return (x > 32'd4094) ? 16'hFFFF : 16'({x[11:0] + 12'd1, 4'd0});
   endfunction

   always_comb begin
      step_in = step_ff; bcnt_in = bcnt_ff; gz_in = gz_ff; fv_in = fv_ff;
      prof_in = prof_ff; cyc_in = cyc_ff; wid_in = wid_ff; hgt_in = hgt_ff;
      tick_in = tick_ff; scale_in = scale_ff; fl_in = fl_ff;
      w = width_of(step_ff);
      fin = 1'b0; v = '0; n = step_ff + 6'd1; stop_now = 1'b0;
      shv = {fv_ff[30:0], bit_value};
      full = ({1'b0, 32'd1} << gz_ff) - 33'd1 + {1'b0, shv};
      cyc_dec = cyc_ff - 8'd1;
      if (bit_valid && step_ff < ST_DONE) begin
         if (w != 6'd0) begin
            fv_in = shv; bcnt_in = bcnt_ff - 6'd1;
            if (bcnt_ff == 6'd1) begin fin = 1'b1; v = shv; end
         end else if (!fl_ff.suffix) begin
            if (!bit_value) begin
               if (gz_ff >= 6'(MAX_GOLOMB_ZEROS)) begin
                  fl_in.over = 1'b1; step_in = ST_DONE;
               end else gz_in = gz_ff + 6'd1;
            end else if (gz_ff == 6'd0) begin
               fin = 1'b1; v = '0;
            end else begin
               fl_in.suffix = 1'b1; bcnt_in = gz_ff; fv_in = '0;
            end
         end else begin
            fv_in = shv; bcnt_in = bcnt_ff - 6'd1;
            if (bcnt_ff == 6'd1) begin fin = 1'b1; v = full[31:0]; end
         end
      end
      if (fin) begin
         case (step_ff)
            6'd0: if (v[4:0] != 5'd7) begin stop_now = 1'b1; fl_in.not_sps = 1'b1; end
            6'd1: prof_in = v[7:0];
            6'd4: n = (prof_ff == 8'd100 || prof_ff == 8'd110 || prof_ff == 8'd122 ||
                       prof_ff == 8'd144) ? 6'd5 : 6'd12;
            6'd5: n = (v == 32'd3) ? 6'd6 : 6'd7;
            6'd10: n = (v != 0) ? 6'd11 : 6'd12;
            6'd13: n = (v == 32'd0) ? 6'd14 : (v == 32'd1) ? 6'd15 : 6'd20;
            6'd14: n = 6'd20;
            6'd18: if (v > 32'd255) begin stop_now = 1'b1; fl_in.over = 1'b1; end
                   else begin cyc_in = v[7:0]; n = (v != 0) ? 6'd19 : 6'd20; end
            6'd19: begin cyc_in = cyc_dec; n = (cyc_dec != 0) ? 6'd19 : 6'd20; end
            6'd22: begin wid_in = size_of(v); if (v > 32'd4094) fl_in.sat = 1'b1; end
            6'd23: begin hgt_in = size_of(v); if (v > 32'd4094) fl_in.sat = 1'b1; end
            6'd24: n = (v != 0) ? 6'd26 : 6'd25;
            6'd27: if (v != 0) begin cyc_in = 8'd4; n = 6'd28; end else n = 6'd29;
            6'd28: begin cyc_in = cyc_dec; n = (cyc_dec != 0) ? 6'd28 : 6'd29; end
            6'd29: if (v == 0) begin stop_now = 1'b1; fl_in.complete = 1'b1; end
            6'd30: n = (v != 0) ? 6'd31 : 6'd33;
            6'd31: n = (v == 32'd255) ? 6'd32 : 6'd33;
            6'd33: n = (v != 0) ? 6'd34 : 6'd35;
            6'd35: n = (v != 0) ? 6'd36 : 6'd38;
            6'd36: n = v[0] ? 6'd37 : 6'd38;
            6'd38: if (v != 0) begin cyc_in = 8'd2; n = 6'd39; end else n = 6'd40;
            6'd39: begin cyc_in = cyc_dec; n = (cyc_dec != 0) ? 6'd39 : 6'd40; end
            6'd40: if (v == 0) begin stop_now = 1'b1; fl_in.complete = 1'b1; end
                   else fl_in.timing = 1'b1;
            6'd41: tick_in = v;
            6'd42: scale_in = v;
            6'd43: begin
               stop_now = 1'b1; fl_in.complete = 1'b1;
               if (v[0]) fl_in.fixed = 1'b1;
            end
            default: ;
         endcase
         if (stop_now) step_in = ST_DONE;
         else begin
            step_in = n; bcnt_in = width_of(n); gz_in = '0; fv_in = '0;
            fl_in.suffix = 1'b0;
         end
      end
      if (clear) begin
         step_in = '0; bcnt_in = width_of(6'd0); gz_in = '0; fv_in = '0;
         prof_in = '0; cyc_in = '0; wid_in = '0; hgt_in = '0;
         tick_in = '0; scale_in = '0; fl_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0; bcnt_ff <= width_of(6'd0); gz_ff <= '0; fv_ff <= '0;
         prof_ff <= '0; cyc_ff <= '0; wid_ff <= '0; hgt_ff <= '0;
         tick_ff <= '0; scale_ff <= '0; fl_ff <= '0;
      end else begin
         step_ff <= step_in; bcnt_ff <= bcnt_in; gz_ff <= gz_in; fv_ff <= fv_in;
         prof_ff <= prof_in; cyc_ff <= cyc_in; wid_ff <= wid_in; hgt_ff <= hgt_in;
         tick_ff <= tick_in; scale_ff <= scale_in; fl_ff <= fl_in;
      end
   end

   assign flags        = fl_ff;
   assign width_store  = wid_ff;
   assign height_store = hgt_ff;
   assign tick_units   = tick_ff;
   assign scale_value  = scale_ff;

`ifndef NO_ASSERTIONS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_DONE)
      else $error("syntax step out of range");
   a_notsps_done: assert property (@(posedge clock) disable iff (reset)
      fl_ff.not_sps |-> step_ff == ST_DONE)
      else $error("not-SPS without stop");
   a_complete_done: assert property (@(posedge clock) disable iff (reset)
      fl_ff.complete |-> step_ff == ST_DONE)
      else $error("complete without stop");
`endif
endmodule
`default_nettype wire
